// ===== design/itrs_pkg.sv =====
package itrs_pkg;

	localparam int unsigned VALUE_W   = 32;
	localparam int unsigned RADIX_W   = 8;
	localparam int unsigned CHAR_W    = 8;
	localparam int unsigned LEN_W     = 6;
	localparam int unsigned DIGIT_W   = 4;
	localparam int unsigned BASE_W    = 5;
	localparam int unsigned MAX_DIGITS = 32;
	localparam int unsigned IDX_W     = 5;

	localparam logic [RADIX_W-1:0] RADIX_MIN = 8'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 8'd16;
	localparam logic [RADIX_W-1:0] RADIX_DEC = 8'd10;

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_UPPER = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BAD,
		ST_DIV,
		ST_EMIT
	} state_t;

	// ascii for one digit value, upper-case letters above nine
	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d < 4'd10) begin
			c = CHAR_ZERO + {4'd0, d};
		end else begin
			c = CHAR_UPPER + {4'd0, d} - 8'd10;
		end
		return c;
	endfunction

endpackage

// ===== design/integer_to_radix_string.sv =====
// integer to radix text converter
// input channel s_*: one request carries a 32-bit value and a radix (2 to 16 valid).
// output channel m_*: one request per character, most significant first, upper-case
// letters for digits ten to fifteen; radix ten reads the value as signed and sends a
// leading minus. tlast marks the final character, tuser flags a rejected radix, in
// which case a single request with zero character and zero length is sent.
// a single shared restoring divider (one shift, compare and subtract per cycle) forms
// every digit before the first character leaves; the digits then stream out at one
// per cycle while the receiver takes them.
// s_tready is high only while the converter is idle; the next request may be taken
// while the last character still waits in the output register.
// a receiver stall simply holds the output register and pauses emission.
// reset (arst_n low) empties the output register and returns to idle; the digit
// store is not cleared since every entry is written before it is read.
module integer_to_radix_string (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // value [31:0], radix [39:32]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // char_code [7:0], text_length [13:8], zero [15:14]
	output logic        m_tlast,   // last
	output logic        m_tuser    // bad_base
);

	itrs_pkg::state_t state_q, state_d;

	// request fields
	logic [itrs_pkg::VALUE_W-1:0] in_value;
	logic [itrs_pkg::RADIX_W-1:0] in_radix;
	logic                         radix_ok;
	logic                         in_neg;

	// divider state
	logic [itrs_pkg::VALUE_W-1:0] quo_q;
	logic [itrs_pkg::DIGIT_W-1:0] rem_q;
	logic [itrs_pkg::BASE_W-1:0]  base_q;
	logic [itrs_pkg::IDX_W-1:0]   bit_q;
	logic [itrs_pkg::LEN_W-1:0]   cnt_q;
	logic                         neg_q;
	logic [itrs_pkg::DIGIT_W-1:0] digit_q [itrs_pkg::MAX_DIGITS];

	// emission state
	logic [itrs_pkg::LEN_W-1:0]   ptr_q;
	logic                         sign_q;

	// output register
	logic                         m_tvalid_q;
	logic [itrs_pkg::CHAR_W-1:0]  char_q;
	logic [itrs_pkg::LEN_W-1:0]   len_q;
	logic                         last_q;
	logic                         bad_q;

	// shared divider step
	logic [itrs_pkg::BASE_W-1:0]  rem_shift;
	logic                         rem_ge;
	logic [itrs_pkg::BASE_W-1:0]  rem_sub;
	logic [itrs_pkg::DIGIT_W-1:0] rem_next;
	logic [itrs_pkg::VALUE_W-1:0] quo_next;
	logic                         digit_done;

	// control from the sequencer
	logic                         take_req;
	logic                         out_free;
	logic                         load_bad;
	logic                         load_char;
	logic [itrs_pkg::CHAR_W-1:0]  char_d;
	logic                         last_d;
	logic [itrs_pkg::LEN_W-1:0]   total;
	logic [itrs_pkg::LEN_W-1:0]   ptr_dec;

	assign in_value = s_tdata[31:0];
	assign in_radix = s_tdata[39:32];
	assign radix_ok = in_radix inside {[itrs_pkg::RADIX_MIN:itrs_pkg::RADIX_MAX]};
	assign in_neg   = (in_radix == itrs_pkg::RADIX_DEC) && in_value[31];

	assign rem_shift = {rem_q, quo_q[31]};
	assign rem_ge    = (rem_shift >= base_q);
	assign rem_sub   = rem_shift - base_q;
	assign rem_next  = rem_ge ? rem_sub[itrs_pkg::DIGIT_W-1:0]
	                          : rem_shift[itrs_pkg::DIGIT_W-1:0];
	assign quo_next  = {quo_q[30:0], rem_ge};
	// last bit of the current digit
	assign digit_done = (bit_q == 5'd31);

	assign total    = cnt_q + {5'd0, neg_q};
	assign ptr_dec  = ptr_q - 6'd1;
	assign out_free = !m_tvalid_q || m_tready;
	assign take_req = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= itrs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		load_bad  = 1'b0;
		load_char = 1'b0;
		char_d    = itrs_pkg::CHAR_MINUS;
		last_d    = 1'b0;
		case (state_q)
			itrs_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = radix_ok ? itrs_pkg::ST_DIV : itrs_pkg::ST_BAD;
				end
			end
			itrs_pkg::ST_BAD: begin
				if (out_free) begin
					load_bad = 1'b1;
					state_d  = itrs_pkg::ST_IDLE;
				end
			end
			itrs_pkg::ST_DIV: begin
				// stop once the quotient runs out or the store is full
				if (digit_done && ((quo_next == '0) || (cnt_q == 6'd31))) begin
					state_d = itrs_pkg::ST_EMIT;
				end
			end
			itrs_pkg::ST_EMIT: begin
				if (sign_q) begin
					char_d = itrs_pkg::CHAR_MINUS;
					last_d = (ptr_q == '0);
				end else begin
					char_d = itrs_pkg::digit_char(digit_q[ptr_dec[itrs_pkg::IDX_W-1:0]]);
					last_d = (ptr_q == 6'd1);
				end
				if (out_free) begin
					load_char = 1'b1;
					if (last_d) begin
						state_d = itrs_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = itrs_pkg::ST_IDLE;
			end
		endcase
	end

	// divider and emission control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quo_q  <= '0;
			rem_q  <= '0;
			base_q <= '0;
			bit_q  <= '0;
			cnt_q  <= '0;
			neg_q  <= 1'b0;
			ptr_q  <= '0;
			sign_q <= 1'b0;
		end else begin
			if (take_req && radix_ok) begin
				quo_q  <= in_neg ? (32'd0 - in_value) : in_value;
				rem_q  <= '0;
				base_q <= in_radix[itrs_pkg::BASE_W-1:0];
				bit_q  <= '0;
				cnt_q  <= '0;
				neg_q  <= in_neg;
			end else if (state_q == itrs_pkg::ST_DIV) begin
				quo_q <= quo_next;
				bit_q <= bit_q + 5'd1;
				if (digit_done) begin
					rem_q <= '0;
					cnt_q <= cnt_q + 6'd1;
					// emission pointer starts at the digit count, sign first
					ptr_q  <= cnt_q + 6'd1;
					sign_q <= neg_q;
				end else begin
					rem_q <= rem_next;
				end
			end else if (load_char) begin
				if (sign_q) begin
					sign_q <= 1'b0;
				end else begin
					ptr_q <= ptr_dec;
				end
			end
		end
	end

	// digit store, least significant digit at index zero
	always_ff @(posedge clk) begin
		if ((state_q == itrs_pkg::ST_DIV) && digit_done) begin
			digit_q[cnt_q[itrs_pkg::IDX_W-1:0]] <= rem_next;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_bad || load_char) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_bad) begin
			char_q <= '0;
			len_q  <= '0;
			last_q <= 1'b1;
			bad_q  <= 1'b1;
		end else if (load_char) begin
			char_q <= char_d;
			len_q  <= total;
			last_q <= last_d;
			bad_q  <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, len_q, char_q};
	assign m_tlast  = last_q;
	assign m_tuser  = bad_q;

endmodule
